// ===== hdl/lru_eviction_order_tracker_macros.svh =====
// assertion macros for the lru eviction order tracker checker
// depends on nothing; included by the checker file only
`ifndef LRU_EVICTION_ORDER_TRACKER_MACROS_SVH
`define LRU_EVICTION_ORDER_TRACKER_MACROS_SVH

// same-cycle implication, ignored while reset is low
`define LRU_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("%m: check failed");

// next-cycle implication, ignored while reset is low
`define LRU_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("%m: check failed");

// next-cycle implication that also holds across reset
`define LRU_ASSERT_NXT_ALWAYS(label, clk, pre, post) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("%m: check failed");

`endif

// ===== hdl/lru_pkg.sv =====
// shared sizes, codes and structs of the lru eviction order tracker
// no dependencies; imported by every module of the block but lru_ram
package lru_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int PTR_BITS  = $clog2(CAPACITY + 1);

    // pointer value meaning no entry
    localparam logic [PTR_BITS-1:0]  NULL_PTR   = PTR_BITS'(CAPACITY);
    localparam logic [PTR_BITS-1:0]  FULL_COUNT = PTR_BITS'(CAPACITY);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(CAPACITY - 1);

    typedef enum logic {
        FUNC_TOUCH = 1'b0,
        FUNC_EVICT = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_EVICTED   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RD_LINK,
        S_UNLINK,
        S_APPEND,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        t_func               func;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [KEY_BITS-1:0] evicted_key;
    } t_res;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        logic [KEY_BITS-1:0]  wdata;
        logic [SLOT_BITS-1:0] raddr;
    } t_key_port;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        logic [PTR_BITS-1:0]  wdata;
        logic [SLOT_BITS-1:0] raddr;
    } t_link_port;

endpackage

// ===== hdl/lru_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing; used for the key store and both link stores
module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lru_ctrl.sv =====
// sequencer of the lru tracker: key scan, unlink and append over the rams
// depends on lru_pkg; drives the key ram and the two link rams
module lru_ctrl
    import lru_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_req       i_req,
    output logic       o_idle,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_res       o_res,
    output t_key_port  o_key_port,
    output t_link_port o_older_port,
    output t_link_port o_newer_port,
    input  logic [KEY_BITS-1:0] i_key_q,
    input  logic [PTR_BITS-1:0] i_older_q,
    input  logic [PTR_BITS-1:0] i_newer_q
);

    t_state r_state, n_state;

    t_req                 r_req;
    t_res                 r_res;
    logic                 r_ins;
    logic [SLOT_BITS-1:0] r_idx;
    logic                 r_pend;
    logic [SLOT_BITS-1:0] r_pend_idx;
    logic [SLOT_BITS-1:0] r_slot;
    logic [PTR_BITS-1:0]  r_oldest;
    logic [PTR_BITS-1:0]  r_newest;
    logic [PTR_BITS-1:0]  r_count;
    logic [CAPACITY-1:0]  r_valid;

    logic                 hit;
    logic                 scan_end;
    logic                 hit_newest;
    logic                 is_evict;
    logic [SLOT_BITS-1:0] free_idx;

    assign is_evict   = (r_req.func == FUNC_EVICT);
    assign hit        = r_pend && r_valid[r_pend_idx] && (i_key_q == r_req.key);
    assign scan_end   = r_pend && (r_pend_idx == LAST_SLOT);
    assign hit_newest = (PTR_BITS'(r_pend_idx) == r_newest);

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.func == FUNC_EVICT) begin
                        n_state = (r_oldest == NULL_PTR) ? S_DONE : S_UNLINK;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = hit_newest ? S_DONE : S_RD_LINK;
                end else if (scan_end) begin
                    n_state = (r_count != FULL_COUNT) ? S_APPEND : S_DONE;
                end
            end
            S_RD_LINK: n_state = S_UNLINK;
            S_UNLINK:  n_state = is_evict ? S_DONE : S_APPEND;
            S_APPEND:  n_state = S_FIN;
            S_FIN:     n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_idle             = 1'b0;
        o_res_valid        = 1'b0;
        o_key_port.we      = 1'b0;
        o_key_port.waddr   = r_slot;
        o_key_port.wdata   = r_req.key;
        o_key_port.raddr   = r_idx;
        o_older_port.we    = 1'b0;
        o_older_port.waddr = r_slot;
        o_older_port.wdata = r_newest;
        o_older_port.raddr = r_slot;
        o_newer_port.we    = 1'b0;
        o_newer_port.waddr = r_slot;
        o_newer_port.wdata = NULL_PTR;
        o_newer_port.raddr = r_slot;
        unique case (r_state)
            S_IDLE: begin
                o_idle             = 1'b1;
                // prefetch the oldest entry for an evict
                o_key_port.raddr   = r_oldest[SLOT_BITS-1:0];
                o_older_port.raddr = r_oldest[SLOT_BITS-1:0];
                o_newer_port.raddr = r_oldest[SLOT_BITS-1:0];
            end
            S_SEARCH: begin
                o_key_port.raddr = r_idx;
            end
            S_RD_LINK: begin
                o_older_port.raddr = r_slot;
                o_newer_port.raddr = r_slot;
            end
            S_UNLINK: begin
                o_newer_port.we    = (i_older_q != NULL_PTR);
                o_newer_port.waddr = i_older_q[SLOT_BITS-1:0];
                o_newer_port.wdata = i_newer_q;
                o_older_port.we    = (i_newer_q != NULL_PTR);
                o_older_port.waddr = i_newer_q[SLOT_BITS-1:0];
                o_older_port.wdata = i_older_q;
            end
            S_APPEND: begin
                o_key_port.we      = r_ins;
                o_older_port.we    = 1'b1;
                o_older_port.waddr = r_slot;
                o_older_port.wdata = r_newest;
                o_newer_port.we    = (r_newest != NULL_PTR);
                o_newer_port.waddr = r_newest[SLOT_BITS-1:0];
                o_newer_port.wdata = PTR_BITS'(r_slot);
            end
            S_FIN: begin
                o_newer_port.we    = 1'b1;
                o_newer_port.waddr = r_slot;
                o_newer_port.wdata = NULL_PTR;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= NULL_PTR;
            r_newest <= NULL_PTR;
            r_count  <= '0;
            r_valid  <= '0;
            r_pend   <= 1'b0;
            r_ins    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req             <= i_req;
                        r_idx             <= '0;
                        r_pend            <= 1'b0;
                        r_ins             <= 1'b0;
                        r_slot            <= r_oldest[SLOT_BITS-1:0];
                        r_res.evicted_key <= '0;
                        r_res.status      <= ST_EMPTY;
                    end
                end
                S_SEARCH: begin
                    r_pend     <= 1'b1;
                    r_pend_idx <= r_idx;
                    if (r_idx != LAST_SLOT) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (hit) begin
                        r_slot       <= r_pend_idx;
                        r_res.status <= ST_REFRESHED;
                    end else if (scan_end) begin
                        if (r_count != FULL_COUNT) begin
                            r_slot       <= free_idx;
                            r_ins        <= 1'b1;
                            r_res.status <= ST_INSERTED;
                        end else begin
                            r_res.status <= ST_FULL;
                        end
                    end
                end
                S_UNLINK: begin
                    if (i_older_q == NULL_PTR) begin
                        r_oldest <= i_newer_q;
                    end
                    if (i_newer_q == NULL_PTR) begin
                        r_newest <= i_older_q;
                    end
                    if (is_evict) begin
                        r_valid[r_slot]   <= 1'b0;
                        r_count           <= r_count - 1'b1;
                        r_res.status      <= ST_EVICTED;
                        r_res.evicted_key <= i_key_q;
                    end
                end
                S_APPEND: begin
                    if (r_newest == NULL_PTR) begin
                        r_oldest <= PTR_BITS'(r_slot);
                    end
                    r_newest <= PTR_BITS'(r_slot);
                    if (r_ins) begin
                        r_valid[r_slot] <= 1'b1;
                        r_count         <= r_count + 1'b1;
                    end
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

endmodule

// ===== hdl/lru_eviction_order_tracker.sv =====
// top level of the lru eviction order tracker: stream ports, rams, result register
// depends on lru_pkg, lru_ram and lru_ctrl
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser = func, tdata = key
//  m_axis    out  tvalid/tready          tuser = status, tdata = evicted_key
//
// one beat at a time: the sequencer takes a beat only when idle
// touch scans the key ram one entry a cycle,
//   bounded by the single read port of the key ram
// evict reads the oldest entry and unlinks it, and skips the unlink on an empty store
// the result register frees the sequencer while a result waits for m_axis_tready
// reset is synchronous, active low; all slots come out of reset empty
module lru_eviction_order_tracker
    import lru_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [KEY_BITS-1:0] s_axis_tdata,   // [31:0] key
    input  logic                s_axis_tuser,   // [0] func
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [KEY_BITS-1:0] m_axis_tdata,   // [31:0] evicted_key
    output logic [2:0]          m_axis_tuser    // [2:0] status
);

    logic       idle;
    logic       start;
    t_req       req;
    logic       res_valid;
    logic       res_ready;
    t_res       res;
    t_key_port  key_port;
    t_link_port older_port;
    t_link_port newer_port;

    logic [KEY_BITS-1:0] key_q;
    logic [PTR_BITS-1:0] older_q;
    logic [PTR_BITS-1:0] newer_q;

    logic                r_out_vld;
    t_status             r_out_status;
    logic [KEY_BITS-1:0] r_out_key;

    // input beat goes straight to the sequencer
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign req.key       = s_axis_tdata;
    assign req.func      = t_func'(s_axis_tuser);

    // result register can take a new result once it is empty or draining
    assign res_ready = !r_out_vld || m_axis_tready;

    lru_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (req),
        .o_idle       (idle),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_key_port   (key_port),
        .o_older_port (older_port),
        .o_newer_port (newer_port),
        .i_key_q      (key_q),
        .i_older_q    (older_q),
        .i_newer_q    (newer_q)
    );

    // key per slot
    lru_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_port.we),
        .i_waddr (key_port.waddr),
        .i_wdata (key_port.wdata),
        .i_raddr (key_port.raddr),
        .o_rdata (key_q)
    );

    // link toward the older neighbor of each slot
    lru_ram #(
        .WIDTH (PTR_BITS),
        .DEPTH (CAPACITY)
    ) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (older_port.we),
        .i_waddr (older_port.waddr),
        .i_wdata (older_port.wdata),
        .i_raddr (older_port.raddr),
        .o_rdata (older_q)
    );

    // link toward the newer neighbor of each slot
    lru_ram #(
        .WIDTH (PTR_BITS),
        .DEPTH (CAPACITY)
    ) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (newer_port.we),
        .i_waddr (newer_port.waddr),
        .i_wdata (newer_port.wdata),
        .i_raddr (newer_port.raddr),
        .o_rdata (newer_q)
    );

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_status <= res.status;
            r_out_key    <= res.evicted_key;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_key;
    assign m_axis_tuser  = r_out_status;

endmodule

// ===== hdl/lru_checker.sv =====
// port-level checks of the lru eviction order tracker, bound to the top level
// depends on lru_pkg and lru_eviction_order_tracker_macros.svh
`include "lru_eviction_order_tracker_macros.svh"

module lru_checker
    import lru_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [KEY_BITS-1:0] m_axis_tdata,
    input logic [2:0]          m_axis_tuser
);

    logic              in_beat;
    logic              out_stall;
    logic              not_evicted;
    logic [KEY_BITS+2:0] out_beat;

    assign in_beat     = s_axis_tvalid && s_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign not_evicted = m_axis_tvalid && (m_axis_tuser != ST_EVICTED);
    assign out_beat    = {m_axis_tuser, m_axis_tdata};

    // only an evict result carries a key
    `LRU_ASSERT_IMP(a_key_zero_unless_evicted, i_clk, i_rst_n, not_evicted, m_axis_tdata == '0)

    // one beat in flight: the sequencer is busy right after it takes a beat
    `LRU_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, !s_axis_tready)

    // a stalled result holds
    `LRU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_beat))

    // no result right after reset
    `LRU_ASSERT_NXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind lru_eviction_order_tracker lru_checker u_lru_checker (.*);

// ===== test/lru_tb_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the lru eviction order tracker: predicts replies and checks them
// depends on lru_pkg for the operation and status codes
package lru_tb_pkg;
    import lru_pkg::*;

    class lru_scoreboard;
        // keys in recency order, oldest at the front
        logic [KEY_BITS-1:0] lru_order[$];
        t_res                pending_replies[$];
        int                  mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endfunction

        // apply one accepted request to the order and queue the reply it causes
        function void note_request(t_func func, logic [KEY_BITS-1:0] key);
            t_res reply;
            int   pos;
            reply.evicted_key = '0;
            pos = -1;
            if (func == FUNC_TOUCH) begin
                for (int i = 0; i < lru_order.size(); i++) begin
                    if (pos < 0 && lru_order[i] == key) begin
                        pos = i;
                    end
                end
                if (pos >= 0) begin
                    // moving the newest key to the back leaves the order as it was
                    lru_order.delete(pos);
                    lru_order.push_back(key);
                    reply.status = ST_REFRESHED;
                end else if (lru_order.size() < CAPACITY) begin
                    lru_order.push_back(key);
                    reply.status = ST_INSERTED;
                end else begin
                    reply.status = ST_FULL;
                end
            end else if (lru_order.size() == 0) begin
                reply.status = ST_EMPTY;
            end else begin
                reply.evicted_key = lru_order.pop_front();
                reply.status      = ST_EVICTED;
            end
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(t_status status, logic [KEY_BITS-1:0] evicted_key);
            t_res want;
            if (pending_replies.size() == 0) begin
                report($sformatf("reply with nothing pending: status %0d key %h",
                                 status, evicted_key));
            end else begin
                want = pending_replies.pop_front();
                if (want.status !== status) begin
                    report($sformatf("status: expected %0d, got %0d", want.status, status));
                end
                if (want.evicted_key !== evicted_key) begin
                    report($sformatf("evicted key: expected %h, got %h",
                                     want.evicted_key, evicted_key));
                end
            end
        endfunction
    endclass

endpackage

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench of the lru eviction order tracker: directed then random touch and evict beats
// depends on lru_pkg, lru_tb_pkg and the tracker rtl
module tb;
    import lru_pkg::*;
    import lru_tb_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RANDOM_BEATS = 2000;
    localparam int POOL_SIZE    = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [KEY_BITS-1:0] s_axis_tdata  = '0;    // [31:0] key
    logic                s_axis_tuser  = 1'b0;  // [0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [KEY_BITS-1:0] m_axis_tdata;          // [31:0] evicted_key
    logic [2:0]          m_axis_tuser;          // [2:0] status

    // idle rates in percent, changed between phases of the run
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    lru_scoreboard sb;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    lru_eviction_order_tracker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // receiver: random backpressure, replies checked at the rising edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_reply(t_status'(m_axis_tuser), m_axis_tdata);
        end
    end

    // watchdog: ends the run after a long stretch with no beat on either side
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input t_func func, input logic [KEY_BITS-1:0] key);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= key;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_request(func, key);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
        logic [KEY_BITS-1:0] key;
        int                  evict_pct;
        sb = new();
        evict_pct = 30;
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom();
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 87;

        // directed: empty evict, extreme keys, refresh of newest and of older keys
        send_beat(FUNC_EVICT, '1);
        send_beat(FUNC_TOUCH, '0);
        send_beat(FUNC_TOUCH, '1);
        send_beat(FUNC_TOUCH, '1);
        send_beat(FUNC_TOUCH, '0);
        // fill to capacity, then a new key is rejected while a present one refreshes
        for (int i = 0; i < CAPACITY - 2; i++) begin
            send_beat(FUNC_TOUCH, 32'h5A5A_0000 + i);
        end
        send_beat(FUNC_TOUCH, 32'hC3C3_C3C3);
        send_beat(FUNC_TOUCH, '1);
        repeat (3) send_beat(FUNC_EVICT, '0);
        send_beat(FUNC_TOUCH, 32'hC3C3_C3C3);

        // random: keys mostly from a small pool so that hits, full and refresh all occur
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 33;
            end else if (n == 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // the evict share drifts so the store swings between empty and full
            if (n % 100 == 0) begin
                evict_pct = $urandom_range(10, 60);
            end
            if ($urandom_range(0, 99) < evict_pct) begin
                send_beat(FUNC_EVICT, $urandom());
            end else begin
                key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : $urandom();
                send_beat(FUNC_TOUCH, key);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lru_pkg.sv
hdl/lru_ram.sv
hdl/lru_ctrl.sv
hdl/lru_eviction_order_tracker.sv
hdl/lru_checker.sv
test/lru_tb_pkg.sv
test/tb.sv
